### design/bpgt_pkg.sv
// Shared types, codes and counter helpers for the gshare/tournament branch predictor.
package bpgt_pkg;

   localparam logic [1:0] MODE_STATIC = 2'd0;
   localparam logic [1:0] MODE_GSHARE = 2'd1;
   localparam logic [1:0] MODE_TOURN  = 2'd2;

   localparam logic FUNC_PREDICT = 1'b0;
   localparam logic FUNC_TRAIN   = 1'b1;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_GBITS = 2'd1;
   localparam logic [1:0] CSR_LBITS = 2'd2;
   localparam logic [1:0] CSR_PBITS = 2'd3;

   localparam logic [1:0] MODE_RESET  = MODE_STATIC;
   localparam logic [3:0] GBITS_RESET = 4'd13;
   localparam logic [3:0] LBITS_RESET = 4'd10;
   localparam logic [3:0] PBITS_RESET = 4'd10;

   localparam logic [1:0] CTR_WEAK_NT = 2'b01;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HIST  = 4'b0100,
      ST_CTR   = 4'b1000
   } state_type;

   function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
      logic [1:0] r;
      r = c;
      if (up) begin
         if (c != 2'b11) r = c + 2'd1;
      end else begin
         if (c != 2'b00) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

### design/branch_predictor_gshare_tournament.sv
// Top level of the gshare/tournament conditional branch predictor.
// After reset the block sweeps all tables to their initial values, one entry per cycle,
// holding req_stall high; csr writes are taken throughout. Each request then steps
// through ST_IDLE, ST_HIST and ST_CTR: the transfer cycle issues the global/chooser and
// local-history reads, the next cycle reads the local counter addressed by that history,
// and ST_CTR forms the prediction for a predict request or writes back the updated
// entries for a train request. The dependent local history to local counter lookup is
// why ST_HIST is needed. A prediction waits in ST_CTR only while an earlier result is
// still held by rsp_stall.
module branch_predictor_gshare_tournament
   import bpgt_pkg::*;
#(
   parameter int GLOBAL_HIST_MAX = 13,
   parameter int LOCAL_HIST_MAX  = 11,
   parameter int PC_INDEX_MAX    = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_pc,
   input  logic        req_outcome,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_taken,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int G = GLOBAL_HIST_MAX;
   localparam int L = LOCAL_HIST_MAX;
   localparam int P = PC_INDEX_MAX;
   localparam int GL_MAX   = (G > L) ? G : L;
   localparam int CLR_BITS = (GL_MAX > P) ? GL_MAX : P;

   // configuration
   logic [1:0] mode_ff;
   logic [3:0] gbits_ff, lbits_ff, pbits_ff;

   // control
   state_type           state_ff, state_in;
   logic [CLR_BITS-1:0] clr_ff;
   logic                func_ff, outcome_ff;
   logic [G-1:0]        gaddr_ff, gaddr_in;
   logic [P-1:0]        paddr_ff, paddr_in;
   logic [L-1:0]        laddr_ff, laddr_in;
   logic [G-1:0]        ghist_ff;
   logic                last_local_ff, last_global_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_taken_ff;

   // clamped widths and masks
   logic [4:0]   gbits_eff, lbits_eff, pbits_eff;
   logic [G-1:0] gmask, ghist;
   logic [L-1:0] lmask;
   logic [P-1:0] pmask;

   // memory ports
   logic         gc_rd_en, lh_rd_en, lc_rd_en;
   logic [3:0]   gc_rd_data;
   logic [L-1:0] lh_rd_data;
   logic [1:0]   lc_rd_data;
   logic         gc_wr_en, lh_wr_en, lc_wr_en;
   logic [G-1:0] gc_wr_addr;
   logic [P-1:0] lh_wr_addr;
   logic [L-1:0] lc_wr_addr;
   logic [3:0]   gc_wr_data;
   logic [L-1:0] lh_wr_data;
   logic [1:0]   lc_wr_data;

   logic accept, finish;
   logic ch_dir, g_dir, l_dir, taken;
   logic [1:0] ch_new;

   always_comb begin
      gbits_eff = {1'b0, gbits_ff};
      if (gbits_ff == 4'd0) gbits_eff = 5'd1;
      else if ({1'b0, gbits_ff} > 5'(G)) gbits_eff = 5'(G);
      lbits_eff = {1'b0, lbits_ff};
      if (lbits_ff == 4'd0) lbits_eff = 5'd1;
      else if ({1'b0, lbits_ff} > 5'(L)) lbits_eff = 5'(L);
      pbits_eff = {1'b0, pbits_ff};
      if (pbits_ff == 4'd0) pbits_eff = 5'd1;
      else if ({1'b0, pbits_ff} > 5'(P)) pbits_eff = 5'(P);
   end

   assign gmask = ~({G{1'b1}} << gbits_eff);
   assign lmask = ~({L{1'b1}} << lbits_eff);
   assign pmask = ~({P{1'b1}} << pbits_eff);
   assign ghist = ghist_ff & gmask;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   assign ch_dir = gc_rd_data[3];
   assign g_dir  = gc_rd_data[1];
   assign l_dir  = lc_rd_data[1];
   assign finish = (state_ff == ST_CTR) &&
                   (func_ff == FUNC_TRAIN || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      taken = 1'b1;
      if (mode_ff == MODE_GSHARE) taken = g_dir;
      else if (mode_ff == MODE_TOURN) taken = ch_dir ? l_dir : g_dir;
   end

   always_comb begin
      ch_new = gc_rd_data[3:2];
      if (last_local_ff != last_global_ff) begin
         ch_new = ctr_move(gc_rd_data[3:2], last_local_ff == outcome_ff);
      end
   end

   // next state and read addresses
   always_comb begin
      state_in = state_ff;
      gaddr_in = gaddr_ff;
      paddr_in = paddr_ff;
      laddr_in = laddr_ff;
      gc_rd_en = 1'b0;
      lh_rd_en = 1'b0;
      lc_rd_en = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               gc_rd_en = 1'b1;
               lh_rd_en = 1'b1;
               if (mode_ff == MODE_GSHARE) gaddr_in = (req_pc[G-1:0] ^ ghist) & gmask;
               else gaddr_in = ghist;
               paddr_in = req_pc[P-1:0] & pmask;
               state_in = ST_HIST;
            end
         end
         ST_HIST: begin
            lc_rd_en = 1'b1;
            laddr_in = lh_rd_data & lmask;
            state_in = ST_CTR;
         end
         ST_CTR: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // write-back and clearing sweep
   always_comb begin
      gc_wr_en   = 1'b0;
      lh_wr_en   = 1'b0;
      lc_wr_en   = 1'b0;
      gc_wr_addr = gaddr_ff;
      lh_wr_addr = paddr_ff;
      lc_wr_addr = laddr_ff;
      gc_wr_data = {gc_rd_data[3:2], ctr_move(gc_rd_data[1:0], outcome_ff)};
      lh_wr_data = ((laddr_ff << 1) & lmask) | L'(outcome_ff);
      lc_wr_data = ctr_move(lc_rd_data, outcome_ff);
      if (state_ff == ST_CLEAR) begin
         gc_wr_en   = 1'b1;
         lh_wr_en   = 1'b1;
         lc_wr_en   = 1'b1;
         gc_wr_addr = clr_ff[G-1:0];
         lh_wr_addr = clr_ff[P-1:0];
         lc_wr_addr = clr_ff[L-1:0];
         gc_wr_data = {CTR_WEAK_NT, CTR_WEAK_NT};
         lh_wr_data = '0;
         lc_wr_data = CTR_WEAK_NT;
      end else if (finish && func_ff == FUNC_TRAIN) begin
         if (mode_ff == MODE_GSHARE) begin
            gc_wr_en = 1'b1;
         end else if (mode_ff == MODE_TOURN) begin
            gc_wr_en   = 1'b1;
            lh_wr_en   = 1'b1;
            lc_wr_en   = 1'b1;
            gc_wr_data = {ch_new, ctr_move(gc_rd_data[1:0], outcome_ff)};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (finish && func_ff == FUNC_PREDICT) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RESET;
         gbits_ff       <= GBITS_RESET;
         lbits_ff       <= LBITS_RESET;
         pbits_ff       <= PBITS_RESET;
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         ghist_ff       <= '0;
         last_local_ff  <= 1'b0;
         last_global_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:  mode_ff  <= csr_data[1:0];
               CSR_GBITS: gbits_ff <= csr_data;
               CSR_LBITS: lbits_ff <= csr_data;
               CSR_PBITS: pbits_ff <= csr_data;
               default:   mode_ff  <= mode_ff;
            endcase
         end
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + CLR_BITS'(1);
         if (finish) begin
            if (func_ff == FUNC_PREDICT) begin
               if (mode_ff == MODE_GSHARE) begin
                  last_global_ff <= g_dir;
               end else if (mode_ff == MODE_TOURN) begin
                  last_global_ff <= g_dir;
                  last_local_ff  <= l_dir;
               end
            end else if (mode_ff == MODE_GSHARE || mode_ff == MODE_TOURN) begin
               ghist_ff <= ((ghist << 1) & gmask) | G'(outcome_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         outcome_ff <= req_outcome;
      end
      gaddr_ff <= gaddr_in;
      paddr_ff <= paddr_in;
      laddr_ff <= laddr_in;
      if (finish && func_ff == FUNC_PREDICT) rsp_taken_ff <= taken;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_taken = rsp_taken_ff;

   // {chooser, global} counters share one index
   bpgt_ram #(.WIDTH(4), .DEPTH_BITS(G)) u_gc_ram (
      .clock   (clock),
      .rd_en   (gc_rd_en),
      .rd_addr (gaddr_in),
      .rd_data (gc_rd_data),
      .wr_en   (gc_wr_en),
      .wr_addr (gc_wr_addr),
      .wr_data (gc_wr_data)
   );

   bpgt_ram #(.WIDTH(L), .DEPTH_BITS(P)) u_lh_ram (
      .clock   (clock),
      .rd_en   (lh_rd_en),
      .rd_addr (paddr_in),
      .rd_data (lh_rd_data),
      .wr_en   (lh_wr_en),
      .wr_addr (lh_wr_addr),
      .wr_data (lh_wr_data)
   );

   bpgt_ram #(.WIDTH(2), .DEPTH_BITS(L)) u_lc_ram (
      .clock   (clock),
      .rd_en   (lc_rd_en),
      .rd_addr (laddr_in),
      .rd_data (lc_rd_data),
      .wr_en   (lc_wr_en),
      .wr_addr (lc_wr_addr),
      .wr_data (lc_wr_data)
   );

endmodule

### design/bpgt_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bpgt_ram #(
   parameter int WIDTH      = 2,
   parameter int DEPTH_BITS = 11
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [DEPTH_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data,
   input  logic                  wr_en,
   input  logic [DEPTH_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data
);

   logic [WIDTH-1:0] mem [2**DEPTH_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/bpgt_monitor.sv
// Watches the predictor's channels, models its tables and checks every predicted direction.
module bpgt_monitor
   import bpgt_pkg::*;
#(
   parameter int GHIST_MAX = 13,
   parameter int LHIST_MAX = 11,
   parameter int PIDX_MAX  = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_pc,
   input  logic        req_outcome,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_taken,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data,
   output int          mismatches,
   output int          waiting,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [1:0]           gshare_ctr  [1 << GHIST_MAX];
   logic [1:0]           choice_ctr  [1 << GHIST_MAX];
   logic [1:0]           local_ctr   [1 << LHIST_MAX];
   logic [LHIST_MAX-1:0] branch_hist [1 << PIDX_MAX];
   logic [GHIST_MAX-1:0] path_hist;
   logic                 guess_local;
   logic                 guess_global;
   logic [1:0]           cfg_mode;
   logic [3:0]           cfg_gbits;
   logic [3:0]           cfg_lbits;
   logic [3:0]           cfg_pbits;
   bit                   taken_due [$];

   initial begin
      mismatches = 0;
      checked    = 0;
      waiting    = 0;
   end

   function automatic logic [31:0] width_ones(input logic [3:0] w, input int limit);
      int n;
      n = (w == 4'd0) ? 1 : ((int'(w) > limit) ? limit : int'(w));
      return (32'd1 << n) - 32'd1;
   endfunction

   function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   task automatic report(input string msg);
      $display("%t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic resolve_branch(input logic func, input logic [31:0] pc,
                                 input logic outcome);
      logic [GHIST_MAX-1:0] gmask;
      logic [GHIST_MAX-1:0] ghist;
      logic [GHIST_MAX-1:0] gidx;
      logic [LHIST_MAX-1:0] lmask;
      logic [LHIST_MAX-1:0] lidx;
      logic [PIDX_MAX-1:0]  pmask;
      logic [PIDX_MAX-1:0]  pidx;
      logic                 dir;
      gmask = GHIST_MAX'(width_ones(cfg_gbits, GHIST_MAX));
      lmask = LHIST_MAX'(width_ones(cfg_lbits, LHIST_MAX));
      pmask = PIDX_MAX'(width_ones(cfg_pbits, PIDX_MAX));
      ghist = path_hist & gmask;
      gidx  = (pc[GHIST_MAX-1:0] ^ ghist) & gmask;
      pidx  = pc[PIDX_MAX-1:0] & pmask;
      lidx  = branch_hist[pidx] & lmask;
      if (func == FUNC_PREDICT) begin
         dir = 1'b1;
         case (cfg_mode)
            MODE_GSHARE: begin
               guess_global = gshare_ctr[gidx][1];
               dir = guess_global;
            end
            MODE_TOURN: begin
               guess_local  = local_ctr[lidx][1];
               guess_global = gshare_ctr[ghist][1];
               dir = choice_ctr[ghist][1] ? guess_local : guess_global;
            end
            default: ;
         endcase
         taken_due.push_back(dir);
      end else begin
         case (cfg_mode)
            MODE_GSHARE: begin
               gshare_ctr[gidx] = sat_step(gshare_ctr[gidx], outcome);
               path_hist = ((ghist << 1) & gmask) | GHIST_MAX'(outcome);
            end
            MODE_TOURN: begin
               if (guess_local != guess_global)
                  choice_ctr[ghist] = sat_step(choice_ctr[ghist], guess_local == outcome);
               local_ctr[lidx]   = sat_step(local_ctr[lidx], outcome);
               branch_hist[pidx] = ((lidx << 1) & lmask) | LHIST_MAX'(outcome);
               gshare_ctr[ghist] = sat_step(gshare_ctr[ghist], outcome);
               path_hist = ((ghist << 1) & gmask) | GHIST_MAX'(outcome);
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      bit want;
      if (reset) begin
         for (int i = 0; i < (1 << GHIST_MAX); i++) begin
            gshare_ctr[i] = CTR_WEAK_NT;
            choice_ctr[i] = CTR_WEAK_NT;
         end
         for (int i = 0; i < (1 << LHIST_MAX); i++) local_ctr[i] = CTR_WEAK_NT;
         for (int i = 0; i < (1 << PIDX_MAX); i++) branch_hist[i] = '0;
         path_hist    = '0;
         guess_local  = 1'b0;
         guess_global = 1'b0;
         cfg_mode     = MODE_RESET;
         cfg_gbits    = GBITS_RESET;
         cfg_lbits    = LBITS_RESET;
         cfg_pbits    = PBITS_RESET;
         taken_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (taken_due.size() == 0) begin
               report($sformatf("prediction %b with none outstanding", rsp_taken));
            end else begin
               want = taken_due.pop_front();
               checked++;
               if (rsp_taken !== want)
                  report($sformatf("taken %b, model says %b", rsp_taken, want));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:  cfg_mode  = csr_data[1:0];
               CSR_GBITS: cfg_gbits = csr_data;
               CSR_LBITS: cfg_lbits = csr_data;
               CSR_PBITS: cfg_pbits = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) resolve_branch(req_func, req_pc, req_outcome);
      end
      waiting <= taken_due.size();
   end

endmodule

### tb/testbench.sv
// Top of the branch predictor bench: clock, reset, stimulus, back-pressure and verdict.
module testbench
   import bpgt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int SETTLE     = 8;
   localparam int ITEM_GOAL  = 480;
   localparam int QUIET_FROM = 430;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_func    = FUNC_PREDICT;
   logic [31:0] req_pc      = '0;
   logic        req_outcome = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_taken;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = CSR_MODE;
   logic [3:0]  csr_data    = '0;
   logic        quiet       = 1'b0;

   int mismatches;
   int waiting;
   int checked;
   int sent     = 0;
   int settings = 0;
   int hold_cnt = 0;
   bit gaps_on  = 1'b1;

   always #5 clock = ~clock;

   branch_predictor_gshare_tournament DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_pc, .req_outcome,
      .rsp_valid, .rsp_stall, .rsp_taken,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   bpgt_monitor monitor (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_pc, .req_outcome,
      .rsp_valid, .rsp_stall, .rsp_taken,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .waiting, .checked
   );

   // result-side back-pressure: random-length bursts of stall between calm runs
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
         hold_cnt  <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 4);
      end
   end

   task automatic issue(input logic func, input logic [31:0] pc, input logic outcome);
      if (sent >= QUIET_FROM) quiet <= 1'b1;
      req_func    <= func;
      req_pc      <= pc;
      req_outcome <= outcome;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] m, input logic [3:0] g, input logic [3:0] l,
                            input logic [3:0] p);
      drain();
      write_csr(CSR_MODE, {2'($urandom_range(0, 3)), m});
      write_csr(CSR_GBITS, g);
      write_csr(CSR_LBITS, l);
      write_csr(CSR_PBITS, p);
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic logic [3:0] pick_width(input int span);
      case ($urandom_range(0, 9))
         0:       return 4'd0;
         1:       return 4'd15;
         2:       return 4'd1;
         3:       return 4'(span);
         default: return 4'($urandom_range(1, span));
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      case ($urandom_range(0, 9))
         0:          return MODE_STATIC;
         1:          return MODE_SPARE;
         2, 3, 4, 5: return MODE_GSHARE;
         default:    return MODE_TOURN;
      endcase
   endfunction

   // branch sequences on a small pool of addresses, mostly predict then train
   task automatic run_branches(input int n);
      logic [31:0] pool [6];
      int          bias [6];
      int          k;
      int          r;
      for (int i = 0; i < 6; i++) begin
         pool[i] = $urandom();
         case ($urandom_range(0, 2))
            0:       bias[i] = 3;
            1:       bias[i] = 50;
            default: bias[i] = 97;
         endcase
      end
      pool[5][15:0] = pool[0][15:0];
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (n) begin
         r = $urandom_range(0, 9);
         k = $urandom_range(0, 5);
         if (r == 0) begin
            issue(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
         end else if (r == 1) begin
            issue(FUNC_TRAIN, pool[k], $urandom_range(0, 99) < bias[k]);
         end else begin
            issue(FUNC_PREDICT, pool[k], 1'($urandom_range(0, 1)));
            issue(FUNC_TRAIN, pool[k], $urandom_range(0, 99) < bias[k]);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // static after reset
      issue(FUNC_PREDICT, 32'h0000_0000, 1'b0);
      issue(FUNC_PREDICT, 32'hFFFF_FFFF, 1'b1);
      issue(FUNC_TRAIN,   32'h0000_0000, 1'b1);
      issue(FUNC_TRAIN,   32'hFFFF_FFFF, 1'b0);
      issue(FUNC_PREDICT, 32'h1234_5678, 1'b0);

      configure(MODE_GSHARE, 4'd13, 4'd11, 4'd11);
      issue(FUNC_PREDICT, 32'h0000_0000, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0000, 1'b1);
      issue(FUNC_TRAIN,   32'h0000_0000, 1'b1);
      issue(FUNC_PREDICT, 32'h0000_0000, 1'b0);
      issue(FUNC_TRAIN,   32'hFFFF_FFFF, 1'b0);
      issue(FUNC_PREDICT, 32'hFFFF_FFFF, 1'b1);

      // tournament, first train has no predict before it
      configure(MODE_TOURN, 4'd13, 4'd11, 4'd11);
      issue(FUNC_TRAIN,   32'h0000_0005, 1'b1);
      issue(FUNC_PREDICT, 32'h0000_0005, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0005, 1'b1);
      issue(FUNC_PREDICT, 32'h0000_0005, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0005, 1'b0);
      issue(FUNC_PREDICT, 32'hFFFF_FFFF, 1'b0);
      issue(FUNC_TRAIN,   32'hFFFF_FFFF, 1'b1);

      configure(MODE_SPARE, 4'd13, 4'd10, 4'd10);
      issue(FUNC_PREDICT, 32'h0000_0000, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0000, 1'b0);
      issue(FUNC_PREDICT, 32'h0000_0000, 1'b0);

      // zero widths act as one, oversize widths clamp
      configure(MODE_TOURN, 4'd0, 4'd15, 4'd0);
      issue(FUNC_PREDICT, 32'h0000_0003, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0003, 1'b1);
      issue(FUNC_PREDICT, 32'h0000_0003, 1'b0);
      issue(FUNC_TRAIN,   32'h0000_0003, 1'b1);

      configure(MODE_GSHARE, 4'd15, 4'd0, 4'd15);
      run_branches($urandom_range(15, 35));
      while (sent < ITEM_GOAL) begin
         configure(pick_mode(), pick_width(13), pick_width(11), pick_width(11));
         run_branches($urandom_range(15, 35));
      end

      drain();
      $display("summary: %0d branch requests, %0d predictions compared, %0d settings",
               sent, checked, settings);
      if (mismatches == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d predictions outstanding", waiting);
      $display("testbench: errors");
      $finish;
   end

endmodule

### files.f
design/bpgt_pkg.sv
design/bpgt_ram.sv
design/branch_predictor_gshare_tournament.sv
tb/bpgt_monitor.sv
tb/testbench.sv
